// File: design/pip_pkg.sv
// Shared types and constants for the point-in-polygon test core.
`default_nettype none
package pip_pkg;

	localparam int VIDX_W = 6;
	localparam int CNT_W  = 7;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} pip_state_t;

	typedef struct packed {
		logic start;
		logic load_a;
		logic eval;
	} pip_ctl_t;

	typedef struct packed {
		logic inside_res;
		logic on_edge;
	} pip_res_t;

endpackage
`default_nettype wire

// File: design/pip_in_if.sv
// Request channel: vertex writes and point queries.
`default_nettype none
interface pip_in_if #(parameter int COORD_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [5:0]                    vertex_index;
	logic signed [COORD_WIDTH-1:0] vertex_x;
	logic signed [COORD_WIDTH-1:0] vertex_y;
	logic signed [COORD_WIDTH-1:0] query_x;
	logic signed [COORD_WIDTH-1:0] query_y;

	modport source (output valid, req_type, vertex_index, vertex_x, vertex_y, query_x,
		query_y, input ready);
	modport sink (input valid, req_type, vertex_index, vertex_x, vertex_y, query_x,
		query_y, output ready);
endinterface
`default_nettype wire

// File: design/pip_out_if.sv
// Result channel: inside and on-edge flags.
`default_nettype none
interface pip_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic on_edge;

	modport source (output valid, inside_res, on_edge, input ready);
	modport sink (input valid, inside_res, on_edge, output ready);
endinterface
`default_nettype wire

// File: design/pip_cfg_if.sv
// Configuration write channel for the vertex count register.
`default_nettype none
interface pip_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: design/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/pip_edge_unit.sv
// Shared edge evaluator: cross-product sign, span test and crossing parity.
`default_nettype none
module pip_edge_unit
	import pip_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pip_ctl_t                      ctl,
	input  wire logic signed [COORD_WIDTH-1:0] qx,
	input  wire logic signed [COORD_WIDTH-1:0] qy,
	input  wire logic signed [COORD_WIDTH-1:0] bx,
	input  wire logic signed [COORD_WIDTH-1:0] by,
	output logic                               busy,
	output pip_res_t                           res
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_WIDTH-1:0] px_q, py_q, ax_q, ay_q;

	// stage 1: differences and compare flags
	logic                 ev_s1;
	logic signed [DW-1:0] dpx_s1, dby_s1, dpy_s1, dbx_s1;
	logic                 span_s1, strad_s1, up_s1;

	// stage 2: products
	logic                 ev_s2;
	logic signed [PW-1:0] m1_s2, m2_s2;
	logic                 span_s2, strad_s2, up_s2;

	logic                 edge_q, par_q;

	logic signed [PW:0]   diff;
	logic                 s_zero, s_neg, s_pos;
	logic                 span_c;

	assign span_c = (px_q >= ax_q || px_q >= bx) && (px_q <= ax_q || px_q <= bx) &&
		(py_q >= ay_q || py_q >= by) && (py_q <= ay_q || py_q <= by);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			px_q <= qx;
			py_q <= qy;
		end
		if (ctl.load_a || ctl.eval) begin
			ax_q <= bx;
			ay_q <= by;
		end
		if (ctl.eval) begin
			dpx_s1   <= DW'(px_q) - DW'(ax_q);
			dby_s1   <= DW'(by) - DW'(ay_q);
			dpy_s1   <= DW'(py_q) - DW'(ay_q);
			dbx_s1   <= DW'(bx) - DW'(ax_q);
			span_s1  <= span_c;
			strad_s1 <= (ay_q > py_q) != (by > py_q);
			up_s1    <= by > ay_q;
		end
		if (ev_s1) begin
			m1_s2    <= dpx_s1 * dby_s1;
			m2_s2    <= dpy_s1 * dbx_s1;
			span_s2  <= span_s1;
			strad_s2 <= strad_s1;
			up_s2    <= up_s1;
		end
	end

	assign diff   = (PW + 1)'(m1_s2) - (PW + 1)'(m2_s2);
	assign s_zero = (diff == '0);
	assign s_neg  = diff[PW];
	assign s_pos  = !s_zero && !s_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1  <= 1'b0;
			ev_s2  <= 1'b0;
			edge_q <= 1'b0;
			par_q  <= 1'b0;
		end else begin
			ev_s1 <= ctl.eval;
			ev_s2 <= ev_s1;
			if (ctl.start) begin
				edge_q <= 1'b0;
				par_q  <= 1'b0;
			end else if (ev_s2) begin
				if (s_zero && span_s2) begin
					edge_q <= 1'b1;
				end
				// count an edge that straddles the ray with the point on its inner side
				if (strad_s2 && ((up_s2 && s_neg) || (!up_s2 && s_pos))) begin
					par_q <= !par_q;
				end
			end
		end
	end

	assign busy           = ev_s1 || ev_s2;
	assign res.on_edge    = edge_q;
	assign res.inside_res = edge_q || par_q;

endmodule
`default_nettype wire

// File: design/pip_seq.sv
// Query sequencer: count register, vertex read walk and result register.
`default_nettype none
module pip_seq
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	localparam int AW = $clog2(MAX_VERTICES),
	localparam int NW = $clog2(MAX_VERTICES + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [CNT_W-1:0] cfg_data,
	input  wire logic             in_valid,
	input  wire logic             in_req_type,
	output logic                  in_ready,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output pip_res_t              out_res,
	input  wire logic             unit_busy,
	input  wire pip_res_t         unit_res,
	output pip_ctl_t              ctl,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr
);

	localparam int EW = (NW > CNT_W) ? NW : CNT_W;

	pip_state_t       state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [NW-1:0]    n_vert;
	logic [NW-1:0]    rd_cnt_q;
	logic             rdv_q, first_q;
	logic             out_valid_q;
	pip_res_t         out_res_q;
	logic             query_acc;
	logic             out_load;

	// clamp count to table depth
	assign n_vert = (EW'(count_q) > EW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_q);
	assign query_acc = in_valid && in_ready && (in_req_type == REQ_QUERY);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					state_d = (n_vert == '0) ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				if (rd_cnt_q == n_vert) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rdv_q && !unit_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_READ:   rd_en    = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	// first read fetches the closing vertex, then the table in order
	assign rd_addr = (rd_cnt_q == '0) ? AW'(n_vert - NW'(1)) : AW'(rd_cnt_q - NW'(1));

	assign ctl.start  = query_acc;
	assign ctl.load_a = rdv_q && first_q;
	assign ctl.eval   = rdv_q && !first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			rdv_q       <= 1'b0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			if (query_acc) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + NW'(1);
			end
			rdv_q   <= rd_en;
			first_q <= rd_en && (rd_cnt_q == '0);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= unit_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule
`default_nettype wire

// File: design/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test core.
//
// Channels: in_ch carries a transaction that either writes one vertex
// (req_type 0: vertex_index, vertex_x, vertex_y) or queries a point
// (req_type 1: query_x, query_y). Only a query produces a transaction on
// out_ch (inside_res, on_edge). cfg_ch writes the vertex count; it is always
// ready, and the user must see that it is written only while the core is
// idle; the core does not enforce this. A vertex write leaves the core ready.
// A query with N active vertices (count clamped to MAX_VERTICES) reads the
// vertex RAM once per cycle (N + 1 reads, the closing vertex first), and
// each edge passes a three-stage difference / multiply / sign evaluator;
// for N = 0 nothing is read and the query goes on to the result register.
// in_ch is not ready while a query is in flight; it accepts again in the cycle
// after the result register loads.
// The result sits in an output register; a stalled receiver only holds the
// next query at its final step until the register frees up.
// Reset clears the vertex count and the sequencer; vertex RAM content is
// undefined until written.
`default_nettype none
module point_in_polygon_test_core
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_WIDTH  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pip_in_if.sink    in_ch,
	pip_out_if.source out_ch,
	pip_cfg_if.sink   cfg_ch
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int EW = (NW > VIDX_W) ? NW : VIDX_W;

	pip_ctl_t                  ctl;
	pip_res_t                  unit_res, out_res;
	logic                      unit_busy;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [2*COORD_WIDTH-1:0]  rd_data;
	logic [EW-1:0]             idx_ext;
	logic                      wr_en;
	logic                      in_ready;

	assign idx_ext = EW'(in_ch.vertex_index);
	// drop writes to slots past the table
	assign wr_en = in_ch.valid && in_ready && (in_ch.req_type == REQ_WRITE) &&
		(idx_ext < EW'(MAX_VERTICES));

	pip_ram #(
		.WIDTH(2 * COORD_WIDTH),
		.DEPTH(MAX_VERTICES)
	) u_vert_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_ext[AW-1:0]),
		.wdata ({in_ch.vertex_y, in_ch.vertex_x}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pip_seq #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_ch.valid),
		.cfg_data    (cfg_ch.data),
		.in_valid    (in_ch.valid),
		.in_req_type (in_ch.req_type),
		.in_ready    (in_ready),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.out_res     (out_res),
		.unit_busy   (unit_busy),
		.unit_res    (unit_res),
		.ctl         (ctl),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr)
	);

	pip_edge_unit #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.qx     (in_ch.query_x),
		.qy     (in_ch.query_y),
		.bx     (rd_data[COORD_WIDTH-1:0]),
		.by     (rd_data[2*COORD_WIDTH-1:COORD_WIDTH]),
		.busy   (unit_busy),
		.res    (unit_res)
	);

	assign in_ch.ready       = in_ready;
	assign cfg_ch.ready      = 1'b1;
	assign out_ch.inside_res = out_res.inside_res;
	assign out_ch.on_edge    = out_res.on_edge;

endmodule
`default_nettype wire
